[design/median_extract_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// Median extract queue assertion macros
// Assertion wrappers shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_EXTRACT_QUEUE_UNIT_MACROS_SVH
`define MEDIAN_EXTRACT_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Assert a property on every rising edge outside reset.
`define MEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a condition never holds outside reset.
`define MEQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[design/meq_pkg.sv]
// ----------------------------------------------------------------------------
// Median extract queue package
// Shared defaults and function and status codes.
// ----------------------------------------------------------------------------
package meq_pkg;
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
endpackage

[design/meq_mem.sv]
// ----------------------------------------------------------------------------
// Median extract queue element memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module meq_mem #(
    parameter int DEPTH     = meq_pkg::DEF_CAPACITY,
    parameter int WIDTH     = meq_pkg::DEF_VALUE_BITS,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/median_extract_queue_unit.sv]
// ----------------------------------------------------------------------------
// Median extract queue unit
// Sorted multiset of signed values; insert a value or extract the median.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_valid / o_ready with i_func (0 insert, 1 extract) and
//   i_value. Result channel: o_valid / i_ready with o_status, o_median_value
//   and o_stored_count. Every request gives exactly one result.
//   Elements sit in ascending order in one memory with a registered read.
//   An insert walks down from the top, moving each larger element up one
//   entry until the new value finds its place, at worst entry zero. An
//   extract reads the median entry, then closes the gap by moving each
//   element above it down. Full and empty cases go straight to the result.
//   Each move is a read then a write over the single memory port.
//   One request is worked on at a time; o_ready is high while the sequencer
//   is idle. A finished result sits in an output register, so the next
//   request is accepted while the receiver stalls; a second result then
//   waits in the sequencer until the output register frees up.
//   Reset clears the element count and the output valid flag; the memory
//   needs no clearing since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`include "median_extract_queue_unit_macros.svh"

module median_extract_queue_unit #(
    parameter int CAPACITY   = meq_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = meq_pkg::DEF_VALUE_BITS,
    parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic signed [VALUE_BITS-1:0] o_median_value,
    output logic [CNT_BITS-1:0]          o_stored_count
);
    localparam int ADDR_BITS = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_EXT_RD, S_EXT_GET, S_SH_RD, S_SH_WR, S_DONE
    } t_state;

    t_state                         r_state;
    logic [CNT_BITS-1:0]            r_count;
    logic [CNT_BITS-1:0]            r_pos;
    logic signed [VALUE_BITS-1:0]   r_val;
    logic signed [VALUE_BITS-1:0]   r_med;
    logic [1:0]                     r_status;
    logic                           r_out_valid;
    logic [1:0]                     r_out_status;
    logic signed [VALUE_BITS-1:0]   r_out_med;
    logic [CNT_BITS-1:0]            r_out_count;

    logic                           we;
    logic [ADDR_BITS-1:0]           waddr;
    logic [VALUE_BITS-1:0]          wdata;
    logic [ADDR_BITS-1:0]           raddr;
    logic [VALUE_BITS-1:0]          rdata;
    logic signed [VALUE_BITS-1:0]   rdata_s;
    logic                           accept;
    logic                           out_free;
    logic [CNT_BITS-1:0]            pos_dn;
    logic [CNT_BITS-1:0]            pos_up;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign pos_dn   = r_pos - CNT_BITS'(1);
    assign pos_up   = r_pos + CNT_BITS'(1);
    assign rdata_s  = $signed(rdata);

    meq_mem #(
        .DEPTH     (CAPACITY),
        .WIDTH     (VALUE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Memory port steering: read below/above the walking position, write
    // the moved element or the new value at it.
    always_comb begin
        we    = 1'b0;
        waddr = r_pos[ADDR_BITS-1:0];
        wdata = rdata;
        raddr = r_pos[ADDR_BITS-1:0];
        case (r_state)
            S_INS_RD: begin
                raddr = pos_dn[ADDR_BITS-1:0];
                if (r_pos == '0) begin
                    we    = 1'b1;
                    wdata = r_val;
                end
            end
            S_INS_CMP: begin
                we = 1'b1;
                if (!(rdata_s > r_val)) begin
                    wdata = r_val;
                end
            end
            S_SH_RD: begin
                raddr = pos_up[ADDR_BITS-1:0];
            end
            S_SH_WR: begin
                we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken result unless a new one loads in this cycle.
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val    <= i_value;
                        r_med    <= '0;
                        r_status <= meq_pkg::STATUS_OK;
                        if (i_func == meq_pkg::FUNC_INSERT) begin
                            r_pos <= r_count;
                            if (r_count == CNT_BITS'(CAPACITY)) begin
                                r_status <= meq_pkg::STATUS_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_INS_RD;
                            end
                        end else begin
                            r_pos <= r_count >> 1;
                            if (r_count == '0) begin
                                r_status <= meq_pkg::STATUS_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_EXT_RD;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    // At the bottom: the new value lands in entry zero.
                    if (r_pos == '0) begin
                        r_count <= r_count + CNT_BITS'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (rdata_s > r_val) begin
                        r_pos   <= pos_dn;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + CNT_BITS'(1);
                        r_state <= S_DONE;
                    end
                end
                S_EXT_RD: begin
                    r_state <= S_EXT_GET;
                end
                S_EXT_GET: begin
                    r_med   <= rdata_s;
                    r_state <= S_SH_RD;
                end
                S_SH_RD: begin
                    if (pos_up < r_count) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_count <= r_count - CNT_BITS'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SH_WR: begin
                    r_pos   <= pos_up;
                    r_state <= S_SH_RD;
                end
                S_DONE: begin
                    // Hold the result until the output register frees up.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_med    <= r_med;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_median_value = r_out_med;
    assign o_stored_count = r_out_count;

    `MEQ_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_BITS'(CAPACITY), "count overflow")
    `MEQ_ASSERT(a_idle_count, i_clk, i_rst_n, (r_state == S_IDLE && !accept) |=> $stable(r_count), "count moved while idle")
    `MEQ_NEVER(a_write_range, i_clk, i_rst_n, we && (r_pos > r_count), "write above stored range")
endmodule
